FILE: design/fbpa_pkg.sv
// fbpa_pkg: shared types, widths and codes of the fixed block pool allocator
// no dependencies; imported by every module of the allocator
`default_nettype none

package fbpa_pkg;

  // field widths
  localparam int BIDX_W    = 10;
  localparam int CFG_W     = 11;
  localparam int CMD_W     = 3;
  localparam int STAT_W    = 2;
  localparam int LEDGER_W  = 32;
  localparam int MAX_IDX_W = 16;

  // defaults
  localparam int               DEF_MAX_BLOCKS = 1024;
  localparam logic [CFG_W-1:0] POOL_RESET     = 11'd1024;

  // command codes
  localparam logic [CMD_W-1:0] CMD_ACQUIRE  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_LEDG_CLR = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ARM      = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DISARM   = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK          = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EXHAUSTED   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BAD_RELEASE = 2'd2;
  localparam logic [STAT_W-1:0] STAT_ARMED       = 2'd3;

  // command sequencer
  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } fbpa_state_t;

  // input beat
  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [BIDX_W-1:0]   block_index;
    logic [LEDGER_W-1:0] trigger_threshold;
  } fbpa_in_t;

  // result beat
  typedef struct packed {
    logic [BIDX_W-1:0]   granted_index;
    logic [STAT_W-1:0]   status;
    logic                trigger_fired;
    logic [CFG_W-1:0]    in_use_count;
    logic [CFG_W-1:0]    peak_in_use;
    logic [LEDGER_W-1:0] ledger_count;
  } fbpa_out_t;

  // recycle queue control
  typedef struct packed {
    logic              rd_en;
    logic              pop;
    logic              push;
    logic [BIDX_W-1:0] push_data;
  } fbpa_qctl_t;

  // granted mark control
  typedef struct packed {
    logic                 rd_en;
    logic [MAX_IDX_W-1:0] rd_addr;
    logic                 wr_en;
    logic [MAX_IDX_W-1:0] wr_addr;
    logic                 wr_data;
  } fbpa_mctl_t;

endpackage

`default_nettype wire

FILE: design/fixed_block_pool_allocator.sv
// fixed_block_pool_allocator: top level, command sequencer, counters and result register
// depends on fbpa_pkg, fbpa_queue, fbpa_marks
//
//   channel | direction | handshake           | beat
//   in_     | input     | in_valid / in_stall | fbpa_in_t command
//   out_    | output    | out_valid/out_stall | fbpa_out_t result
//   cfg_    | input     | cfg_valid/cfg_ready | pool_blocks (11 bit)
//
// a command is accepted in idle, which issues the queue and mark ram reads; the exec state
// then uses the read data, writes back and loads the result register.
// the registered ram read of the read-modify-write is why the two states are separate.
// a full result register that is stalled holds the command in the exec state.
// reset is synchronous; no clearing pass, marks past the carve fill read as clear.
`default_nettype none

module fixed_block_pool_allocator #(
  parameter int MAX_BLOCKS = fbpa_pkg::DEF_MAX_BLOCKS
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire fbpa_pkg::fbpa_in_t          in_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output fbpa_pkg::fbpa_out_t              out_data,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [fbpa_pkg::CFG_W-1:0]  cfg_data
);
  import fbpa_pkg::*;

  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int SZ_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  fbpa_state_t         state_r, state_nxt;
  logic                accept, commit, out_free;

  logic [CMD_W-1:0]    cmd_r;
  logic [BIDX_W-1:0]   idx_r;
  logic [LEDGER_W-1:0] thr_in_r;

  logic [CFG_W-1:0]    pool_r;
  logic [CNT_W-1:0]    cursor_r, cursor_nxt;
  logic [CNT_W-1:0]    in_use_r, in_use_nxt;
  logic [CNT_W-1:0]    peak_r, peak_nxt;
  logic [LEDGER_W-1:0] ledger_r, ledger_nxt;
  logic [LEDGER_W-1:0] arm_thr_r, arm_thr_nxt;
  logic                armed_r, armed_nxt;

  logic                out_valid_r;
  fbpa_out_t           out_data_r, res;

  fbpa_qctl_t          qctl;
  fbpa_mctl_t          mctl;
  logic [BIDX_W-1:0]   q_rd_data;
  logic [CNT_W-1:0]    q_count;
  logic                mark_rd;

  logic [SZ_W-1:0]     size;
  logic [BIDX_W-1:0]   blk;
  logic                acq_ok, rel_ok, fired;
  logic [LEDGER_W-1:0] ledger_inc;

  // memories
  fbpa_queue #(.MAX_BLOCKS(MAX_BLOCKS)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (qctl),
    .rd_data (q_rd_data),
    .count   (q_count)
  );

  fbpa_marks #(.MAX_BLOCKS(MAX_BLOCKS)) u_marks (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mctl),
    .rd_data (mark_rd)
  );

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) begin
        state_nxt = ST_EXEC;
      end
      ST_EXEC: if (out_free) begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall = 1'b1;
    commit   = 1'b0;
    unique case (state_r)
      ST_IDLE: in_stall = 1'b0;
      ST_EXEC: commit   = out_free;
      default: in_stall = 1'b1;
    endcase
  end

  assign out_free  = !out_valid_r || !out_stall;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // effective pool size saturates at the pool depth
  always_comb begin
    size = SZ_W'(pool_r);
    if (SZ_W'(pool_r) > SZ_W'(MAX_BLOCKS)) begin
      size = SZ_W'(MAX_BLOCKS);
    end
  end

  assign ledger_inc = (ledger_r != '1) ? ledger_r + 1'b1 : ledger_r;

  // command execution on the ram read data
  always_comb begin
    cursor_nxt  = cursor_r;
    in_use_nxt  = in_use_r;
    ledger_nxt  = ledger_r;
    arm_thr_nxt = arm_thr_r;
    armed_nxt   = armed_r;
    acq_ok      = 1'b0;
    rel_ok      = 1'b0;
    fired       = 1'b0;
    blk         = '0;
    res         = '0;
    res.status  = STAT_OK;
    unique case (cmd_r)
      CMD_ACQUIRE: begin
        if (q_count != '0) begin
          acq_ok = 1'b1;
          blk    = q_rd_data;
        end else if (SZ_W'(cursor_r) < size) begin
          acq_ok     = 1'b1;
          blk        = BIDX_W'(cursor_r);
          cursor_nxt = cursor_r + 1'b1;
        end else begin
          res.status = STAT_EXHAUSTED;
        end
        if (acq_ok) begin
          if (in_use_r < CNT_W'(MAX_BLOCKS)) begin
            in_use_nxt = in_use_r + 1'b1;
          end
          ledger_nxt = ledger_inc;
          if (armed_r && ledger_inc >= arm_thr_r) begin
            fired       = 1'b1;
            armed_nxt   = 1'b0;
            arm_thr_nxt = '0;
          end
        end
      end
      CMD_RELEASE: begin
        if (SZ_W'(idx_r) < size && mark_rd && q_count < CNT_W'(MAX_BLOCKS)) begin
          rel_ok = 1'b1;
          if (in_use_r != '0) begin
            in_use_nxt = in_use_r - 1'b1;
          end
        end else begin
          res.status = STAT_BAD_RELEASE;
        end
      end
      CMD_LEDG_CLR: ledger_nxt = '0;
      CMD_ARM: begin
        if (armed_r) begin
          res.status = STAT_ARMED;
        end else begin
          armed_nxt   = 1'b1;
          arm_thr_nxt = thr_in_r;
        end
      end
      CMD_DISARM: begin
        armed_nxt   = 1'b0;
        arm_thr_nxt = '0;
      end
      default: ;
    endcase
    peak_nxt          = (in_use_nxt > peak_r) ? in_use_nxt : peak_r;
    res.granted_index = acq_ok ? blk : '0;
    res.trigger_fired = fired;
    res.in_use_count  = CFG_W'(in_use_nxt);
    res.peak_in_use   = CFG_W'(peak_nxt);
    res.ledger_count  = ledger_nxt;
  end

  // ram requests: reads on accept, write-back on commit
  always_comb begin
    qctl.rd_en     = accept;
    qctl.pop       = commit && acq_ok && (q_count != '0);
    qctl.push      = commit && rel_ok;
    qctl.push_data = idx_r;
    mctl.rd_en     = accept;
    mctl.rd_addr   = MAX_IDX_W'(in_data.block_index);
    mctl.wr_en     = commit && (acq_ok || rel_ok);
    mctl.wr_addr   = acq_ok ? MAX_IDX_W'(blk) : MAX_IDX_W'(idx_r);
    mctl.wr_data   = acq_ok;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pool_r      <= POOL_RESET;
      cursor_r    <= '0;
      in_use_r    <= '0;
      peak_r      <= '0;
      ledger_r    <= '0;
      arm_thr_r   <= '0;
      armed_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        pool_r <= cfg_data;
      end
      if (commit) begin
        cursor_r  <= cursor_nxt;
        in_use_r  <= in_use_nxt;
        peak_r    <= peak_nxt;
        ledger_r  <= ledger_nxt;
        arm_thr_r <= arm_thr_nxt;
        armed_r   <= armed_nxt;
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // command capture and result register
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r    <= in_data.cmd;
      idx_r    <= in_data.block_index;
      thr_in_r <= in_data.trigger_threshold;
    end
    if (commit) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // every carved block is either granted or waiting in the queue
  a_block_balance: assert property (@(posedge clk) disable iff (!rst_n)
    (CNT_W + 1)'(in_use_r) + (CNT_W + 1)'(q_count) == (CNT_W + 1)'(cursor_r))
    else $error("in-use plus queued blocks differ from carve cursor");

  // peak never falls below the current count
  a_peak_bound: assert property (@(posedge clk) disable iff (!rst_n)
    peak_r >= in_use_r)
    else $error("peak below blocks in use");

  // an accepted beat puts the sequencer in the exec state in the following cycle
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_EXEC)
    else $error("accepted beat not executed");

  // a firing trigger disarms itself
  a_fire_disarm: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && fired) |=> (!armed_r && arm_thr_r == '0))
    else $error("trigger still armed after firing");

  // a commit always lands in the result register
  a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_valid_r)
    else $error("committed result not presented");

endmodule

`default_nettype wire

FILE: design/fbpa_queue.sv
// fbpa_queue: fifo recycle queue of released block indices in a synchronous ram
// depends on fbpa_pkg
`default_nettype none

module fbpa_queue #(
  parameter int MAX_BLOCKS = 1024
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire fbpa_pkg::fbpa_qctl_t               ctl,
  output logic [fbpa_pkg::BIDX_W-1:0]             rd_data,
  output logic [$clog2(MAX_BLOCKS+1)-1:0]         count
);
  import fbpa_pkg::*;

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

  logic [BIDX_W-1:0] mem_r [MAX_BLOCKS];
  logic [BIDX_W-1:0] rd_data_r;
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [IDX_W-1:0]  tail_r, tail_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  // pointer wrap at pool depth
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (ctl.pop) begin
      head_nxt  = (head_r == IDX_W'(MAX_BLOCKS - 1)) ? '0 : head_r + 1'b1;
      count_nxt = count_r - 1'b1;
    end
    if (ctl.push) begin
      tail_nxt  = (tail_r == IDX_W'(MAX_BLOCKS - 1)) ? '0 : tail_r + 1'b1;
      count_nxt = count_r + 1'b1;
    end
  end

  // pointers and fill
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  // queue ram, write at tail, registered read at head
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem_r[tail_r] <= ctl.push_data;
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem_r[head_r];
    end
  end

  assign rd_data = rd_data_r;
  assign count   = count_r;

endmodule

`default_nettype wire

FILE: design/fbpa_marks.sv
// fbpa_marks: granted mark per block in a synchronous ram, fill bound stands in for reset
// depends on fbpa_pkg
`default_nettype none

module fbpa_marks #(
  parameter int MAX_BLOCKS = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire fbpa_pkg::fbpa_mctl_t ctl,
  output logic                      rd_data
);
  import fbpa_pkg::*;

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

  logic             mem_r [MAX_BLOCKS];
  logic             rd_data_r;
  logic [CNT_W-1:0] fill_r;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;

  assign rd_addr = IDX_W'(ctl.rd_addr);
  assign wr_addr = IDX_W'(ctl.wr_addr);

  // entries are first written in ascending order, so fill marks the written part
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (ctl.wr_en && CNT_W'(wr_addr) == fill_r) begin
      fill_r <= fill_r + 1'b1;
    end
  end

  // mark ram; an entry past the fill reads as clear
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem_r[wr_addr] <= ctl.wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem_r[rd_addr] & (CNT_W'(rd_addr) < fill_r);
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: dv/fixed_block_pool_allocator_tb.sv
`timescale 1ns / 100ps
// fixed_block_pool_allocator_tb: self-checking bench for the block pool allocator
// drives commands and pool size writes, predicts every result beat and checks it
// depends on fbpa_pkg and fixed_block_pool_allocator

module fixed_block_pool_allocator_tb;
  import fbpa_pkg::*;

  localparam int MAXB = DEF_MAX_BLOCKS;
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
  localparam logic [LEDGER_W-1:0] LEDGER_MAX = '1;

  logic clk;
  logic rst_n = 1'b0;

  logic             in_valid = 1'b0;
  logic             in_stall;
  fbpa_in_t         in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  fbpa_out_t        out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data = '0;

  // commands waiting for the driver, results waiting for the monitor
  fbpa_in_t  cmd_pending[$];
  fbpa_out_t result_due[$];

  // shadow allocator state
  logic [BIDX_W-1:0]   rq [MAXB];
  bit                  marks [MAXB];
  int unsigned         q_head = 0;
  int unsigned         q_tail = 0;
  int unsigned         q_count = 0;
  int unsigned         carve = 0;
  int unsigned         in_use = 0;
  int unsigned         peak = 0;
  logic [LEDGER_W-1:0] ledger = '0;
  logic [LEDGER_W-1:0] arm_thr = '0;
  bit                  armed = 1'b0;
  int unsigned         pool_cfg = 32'(POOL_RESET);
  int unsigned         held[$];

  // run bookkeeping
  int err_count = 0;
  int beats_sent = 0;
  int grants = 0;
  int exhausted = 0;
  int bad_releases = 0;
  int fires = 0;
  int pool_settings = 1;
  bit no_idle = 1'b0;
  int in_gap = 0;
  int out_gap = 0;

  fixed_block_pool_allocator #(
    .MAX_BLOCKS(MAXB)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // work out the result of one accepted command and advance the shadow state
  task automatic alloc_predict(input fbpa_in_t beat);
    fbpa_out_t   res;
    int unsigned size;
    int unsigned blk;
    int unsigned idx;
    int          loc;
    bit          got;
    res = '0;
    blk = 0;
    idx = 32'(beat.block_index);
    loc = -1;
    got = 1'b1;
    size = (pool_cfg > MAXB) ? MAXB : pool_cfg;
    case (beat.cmd)
      CMD_ACQUIRE: begin
        if (q_count > 0) begin
          blk = 32'(rq[q_head]);
          q_head = (q_head == MAXB - 1) ? 0 : q_head + 1;
          q_count--;
        end else if (carve < size) begin
          blk = carve;
          carve++;
        end else begin
          got = 1'b0;
          res.status = STAT_EXHAUSTED;
          exhausted++;
        end
        if (got) begin
          marks[blk] = 1'b1;
          held.insert(held.size(), blk);
          res.granted_index = blk[BIDX_W-1:0];
          grants++;
          if (in_use < MAXB) in_use++;
          if (in_use > peak) peak = in_use;
          if (ledger != LEDGER_MAX) ledger++;
          // one-shot trigger disarms itself
          if (armed && ledger >= arm_thr) begin
            res.trigger_fired = 1'b1;
            armed = 1'b0;
            arm_thr = '0;
            fires++;
          end
        end
      end
      CMD_RELEASE: begin
        if (idx < size && marks[idx] && q_count < MAXB) begin
          marks[idx] = 1'b0;
          rq[q_tail] = idx[BIDX_W-1:0];
          q_tail = (q_tail == MAXB - 1) ? 0 : q_tail + 1;
          q_count++;
          if (in_use > 0) in_use--;
          for (int k = 0; k < held.size(); k++) begin
            if (loc < 0 && held[k] == idx) loc = k;
          end
          if (loc >= 0) held.delete(loc);
        end else begin
          res.status = STAT_BAD_RELEASE;
          bad_releases++;
        end
      end
      CMD_LEDG_CLR: ledger = '0;
      CMD_ARM: begin
        if (armed) begin
          res.status = STAT_ARMED;
        end else begin
          armed = 1'b1;
          arm_thr = beat.trigger_threshold;
        end
      end
      CMD_DISARM: begin
        armed = 1'b0;
        arm_thr = '0;
      end
      default: ;
    endcase
    res.in_use_count = in_use[CFG_W-1:0];
    res.peak_in_use  = peak[CFG_W-1:0];
    res.ledger_count = ledger;
    result_due.insert(result_due.size(), res);
  endtask

  // compare one result beat against the oldest prediction
  task automatic check_result(input fbpa_out_t got);
    fbpa_out_t exp_res;
    if (result_due.size() == 0) begin
      $error("result beat with nothing outstanding: %h", got);
      err_count++;
    end else begin
      exp_res = result_due[0];
      result_due.delete(0);
      if (got.granted_index !== exp_res.granted_index) begin
        $error("granted_index exp %0d got %0d", exp_res.granted_index, got.granted_index);
        err_count++;
      end
      if (got.status !== exp_res.status) begin
        $error("status exp %0d got %0d", exp_res.status, got.status);
        err_count++;
      end
      if (got.trigger_fired !== exp_res.trigger_fired) begin
        $error("trigger_fired exp %0d got %0d", exp_res.trigger_fired, got.trigger_fired);
        err_count++;
      end
      if (got.in_use_count !== exp_res.in_use_count) begin
        $error("in_use_count exp %0d got %0d", exp_res.in_use_count, got.in_use_count);
        err_count++;
      end
      if (got.peak_in_use !== exp_res.peak_in_use) begin
        $error("peak_in_use exp %0d got %0d", exp_res.peak_in_use, got.peak_in_use);
        err_count++;
      end
      if (got.ledger_count !== exp_res.ledger_count) begin
        $error("ledger_count exp %h got %h", exp_res.ledger_count, got.ledger_count);
        err_count++;
      end
    end
  endtask

  // command driver with random idle bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid && !in_stall) alloc_predict(in_data);
      if (!in_valid || !in_stall) begin
        if (!no_idle && in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (cmd_pending.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= cmd_pending[0];
          cmd_pending.delete(0);
          beats_sent++;
          if (!no_idle && $urandom_range(0, 9) == 0) in_gap = $urandom_range(1, 11);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random stall bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_valid && !out_stall) check_result(out_data);
      if (!no_idle && out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else if (!no_idle && $urandom_range(0, 15) == 0) begin
        out_gap = $urandom_range(0, 10);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // queue one command, keeping the backlog short so picks track the shadow state
  task automatic push_beat(input logic [CMD_W-1:0] cmd, input logic [BIDX_W-1:0] idx,
                           input logic [LEDGER_W-1:0] thr);
    fbpa_in_t b;
    while (cmd_pending.size() >= 2) @(posedge clk);
    b.cmd = cmd;
    b.block_index = idx;
    b.trigger_threshold = thr;
    cmd_pending.insert(cmd_pending.size(), b);
  endtask

  // sampled mid-cycle so every beat driven at the last edge is visible
  task automatic wait_idle();
    @(negedge clk);
    while (cmd_pending.size() != 0 || in_valid || result_due.size() != 0) @(negedge clk);
  endtask

  // pool size write, only with the allocator drained
  task automatic write_pool(input logic [CFG_W-1:0] value);
    wait_idle();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    pool_cfg = 32'(value);
    pool_settings++;
    cfg_valid <= 1'b0;
  endtask

  // random traffic, alternating fill-leaning and drain-leaning stretches
  task automatic random_beats(input int count);
    int               roll;
    int               a_lim;
    int               r_lim;
    bit               fill;
    logic [CMD_W-1:0] cmd;
    logic [BIDX_W-1:0] idx;
    logic [LEDGER_W-1:0] thr;
    fill = 1'b1;
    for (int n = 0; n < count; n++) begin
      if (n % 32 == 31) fill = ~fill;
      a_lim = fill ? 55 : 25;
      r_lim = a_lim + (fill ? 25 : 50);
      roll = $urandom_range(0, 99);
      idx = BIDX_W'($urandom_range(0, MAXB - 1));
      thr = $urandom;
      if (roll < a_lim) begin
        cmd = CMD_ACQUIRE;
      end else if (roll < r_lim) begin
        cmd = CMD_RELEASE;
        if (held.size() > 0 && $urandom_range(0, 4) != 0)
          idx = BIDX_W'(held[$urandom_range(0, held.size() - 1)]);
      end else if (roll < r_lim + 4) begin
        cmd = CMD_LEDG_CLR;
      end else if (roll < r_lim + 12) begin
        cmd = CMD_ARM;
        case ($urandom_range(0, 3))
          0, 1: thr = ledger + $urandom_range(1, 6);
          2: thr = '0;
          default: ;
        endcase
      end else if (roll < r_lim + 17) begin
        cmd = CMD_DISARM;
      end else begin
        cmd = CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
      end
      push_beat(cmd, idx, thr);
    end
  endtask

  // stimulus sequence
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty releases, carving, trigger corners, recycle, spare codes
    push_beat(CMD_RELEASE, '0, '0);
    push_beat(CMD_RELEASE, BIDX_W'(MAXB - 1), '1);
    push_beat(CMD_ACQUIRE, '1, '1);
    push_beat(CMD_ACQUIRE, '0, '0);
    push_beat(CMD_ARM, '0, '0);
    push_beat(CMD_ARM, '0, 32'd5);
    push_beat(CMD_ACQUIRE, '0, '0);
    push_beat(CMD_DISARM, '0, '0);
    push_beat(CMD_ARM, '0, LEDGER_MAX);
    push_beat(CMD_ACQUIRE, '0, '0);
    push_beat(CMD_DISARM, '1, '1);
    push_beat(CMD_RELEASE, 10'd1, '0);
    push_beat(CMD_RELEASE, 10'd1, '0);
    push_beat(CMD_ACQUIRE, '0, '0);
    push_beat(CMD_LEDG_CLR, '1, '1);
    push_beat(CMD_SPARE_LO, '1, '1);
    push_beat(CMD_SPARE_LO + 3'd1, '0, '0);
    push_beat(CMD_SPARE_HI, '1, '0);
    push_beat(CMD_ARM, '0, 32'd3);
    push_beat(CMD_ACQUIRE, '0, '0);
    push_beat(CMD_ACQUIRE, '0, '0);
    push_beat(CMD_ACQUIRE, '0, '0);
    push_beat(CMD_RELEASE, '0, '0);
    push_beat(CMD_RELEASE, 10'd2, '0);

    // empty pool: every acquire past the queue is exhausted
    write_pool(11'd0);
    push_beat(CMD_ACQUIRE, '0, '0);
    push_beat(CMD_RELEASE, 10'd3, '0);
    random_beats(30);

    write_pool(11'd1);
    random_beats(100);
    write_pool(11'd3);
    random_beats(120);
    write_pool(11'd16);
    random_beats(150);
    // shrink below granted blocks
    write_pool(11'd5);
    random_beats(120);
    write_pool(11'd40);
    random_beats(150);
    // above the block count, saturates
    write_pool(11'h7FF);
    random_beats(150);
    write_pool(11'd2);
    random_beats(100);

    // closing stretch at full size, back to back
    write_pool(POOL_RESET);
    wait_idle();
    no_idle = 1'b1;
    random_beats(300);

    wait_idle();
    repeat (20) @(posedge clk);
    $display("run covered %0d commands over %0d pool sizes", beats_sent, pool_settings);
    $display("  %0d grants, %0d exhausted, %0d bad releases, %0d trigger fires",
             grants, exhausted, bad_releases, fires);
    if (err_count == 0 && result_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      if (result_due.size() != 0) $error("%0d results never arrived", result_due.size());
      $display("DONE: errors detected");
    end
    $finish;
  end

  // hang guard
  initial begin
    #2000000;
    $error("timeout with %0d results outstanding", result_due.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: files.f
design/fbpa_pkg.sv
design/fbpa_queue.sv
design/fbpa_marks.sv
design/fixed_block_pool_allocator.sv
dv/fixed_block_pool_allocator_tb.sv
